// ===== rtl/core/m32r_xu_pkg.sv =====
// Package for the M32R subset execute unit: word types, status codes,
// opcode masks and opcode values. Depends on nothing.
package m32r_xu_pkg;

   // Default byte size of the program space checked against the sequential PC
   localparam int unsigned MEM_BYTES_DEFAULT = 4096;

   // Result status codes
   typedef enum logic [2:0] {
      ST_DONE       = 3'd0,
      ST_TRAP_STOP  = 3'd1,
      ST_DECODE_ERR = 3'd2,
      ST_PC_RANGE   = 3'd3,
      ST_HALTED     = 3'd4
   } status_type;

   // Input word: one fetched instruction
   typedef struct packed {
      logic [15:0] first_half;
      logic [15:0] second_half;
   } req_word_type;

   // Result word: outcome of one instruction
   typedef struct packed {
      status_type         status;
      logic [31:0]        exec_pc;
      logic [31:0]        following_pc;
      logic               cond_flag;
      logic               reg_written;
      logic [3:0]         reg_index;
      logic signed [31:0] reg_value;
   } rsp_word_type;

   // Decode masks
   localparam logic [15:0] MASK_MAJOR = 16'hf0f0;
   localparam logic [15:0] MASK_HIGH  = 16'hff00;
   localparam logic [15:0] MASK_RS    = 16'hfff0;
   localparam logic [15:0] MASK_TOP   = 16'hf000;
   localparam logic [15:0] MASK_RD    = 16'hf0ff;
   localparam logic [31:0] PC_ALIGN   = 32'hffff_fffc;

   // Opcodes matched under MASK_MAJOR
   localparam logic [15:0] OPC_ADD    = 16'h00a0;
   localparam logic [15:0] OPC_ADD3   = 16'h80a0;
   localparam logic [15:0] OPC_AND    = 16'h00c0;
   localparam logic [15:0] OPC_BEQ    = 16'hb000;
   localparam logic [15:0] OPC_CMP    = 16'h0040;
   localparam logic [15:0] OPC_MUL    = 16'h1060;
   localparam logic [15:0] OPC_MV     = 16'h1080;
   localparam logic [15:0] OPC_NEG    = 16'h0030;
   localparam logic [15:0] OPC_NOT    = 16'h00b0;
   localparam logic [15:0] OPC_OR     = 16'h00e0;
   localparam logic [15:0] OPC_OR3    = 16'h80e0;
   localparam logic [15:0] OPC_SLL    = 16'h1040;
   localparam logic [15:0] OPC_SLLI_A = 16'h5040;
   localparam logic [15:0] OPC_SLLI_B = 16'h5050;
   localparam logic [15:0] OPC_SRL    = 16'h1000;
   localparam logic [15:0] OPC_SRLI_A = 16'h5000;
   localparam logic [15:0] OPC_SRLI_B = 16'h5010;
   localparam logic [15:0] OPC_SUB    = 16'h0020;
   localparam logic [15:0] OPC_XOR    = 16'h00d0;

   // Opcodes matched under the other masks
   localparam logic [15:0] OPC_BC     = 16'h7c00;
   localparam logic [15:0] OPC_BRA    = 16'h7f00;
   localparam logic [15:0] OPC_CMPI   = 16'h8040;
   localparam logic [15:0] OPC_JL     = 16'h1ec0;
   localparam logic [15:0] OPC_JMP    = 16'h1fc0;
   localparam logic [15:0] OPC_TRAP   = 16'h10f0;
   localparam logic [15:0] OPC_ADDI   = 16'h4000;
   localparam logic [15:0] OPC_LDI    = 16'h90f0;
   localparam logic [15:0] OPC_NOP    = 16'h7000;
   localparam logic [15:0] OPC_SETH   = 16'hd0c0;

   // Register written by jump-and-link
   localparam logic [3:0] LINK_REG = 4'd14;

endpackage

// ===== rtl/core/m32r_subset_execute_unit.sv =====
// M32R subset execute unit: register file, PC, C bit and a one-pass execute
// stage between an input word register and a result word register.
// Depends on m32r_xu_pkg.
//
//   channel | ports                          | direction | word
//   --------+--------------------------------+-----------+---------------
//   request | req_valid req_stall req_data   | in        | req_word_type
//   result  | rsp_valid rsp_stall rsp_data   | out       | rsp_word_type
//
// One instruction a cycle while the result is not stalled: a word enters
// the input register, executes and lands in the result register; the execute
// path (32x32 multiply or 32-bit add and compare) sets the cycle time.
// Register file reads happen as a word is taken, with a bypass from the write
// of the instruction leaving the execute stage on that same edge.
// Synchronous reset clears PC, C, halt flag and register file valid bits.
// A stalled result holds the execute stage; req_stall rises only then and
// while reset is high.
module m32r_subset_execute_unit #(
   parameter int unsigned MEM_BYTES = m32r_xu_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  m32r_xu_pkg::req_word_type  req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output m32r_xu_pkg::rsp_word_type  rsp_data
);
   import m32r_xu_pkg::*;

   localparam logic [31:0] MEM_LIMIT = 32'(MEM_BYTES);

   // Architectural state
   logic [31:0]  pc_ff, pc_in;
   logic         carry_ff, carry_in;
   logic         halted_ff, halted_in;
   logic [31:0]  rf_mem [16];
   logic [15:0]  rf_valid_ff;

   // Execute stage
   logic          s1_valid_ff;
   req_word_type  s1_word_ff;
   logic [31:0]   s1_a_ff, s1_b_ff;

   // Result register
   logic          rsp_valid_ff;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // Handshake
   logic s1_move, s1_load;

   // Execute results
   logic [15:0]  c1, c2;
   logic [31:0]  base_pc, seq_pc, imm16_sx, imm8_sx, br16_off, br8_off, prod;
   status_type   ex_status;
   logic [31:0]  ex_next, ex_wval;
   logic         ex_wr, ex_carry, known, ex_stop;
   logic [3:0]   ex_widx;
   logic         rf_we;
   logic [3:0]   rd_addr, rs_addr;

   // Stage movement
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (s1_valid_ff && !s1_move);
   assign s1_load   = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // Decode fields and immediates
   assign c1       = s1_word_ff.first_half;
   assign c2       = s1_word_ff.second_half;
   assign base_pc  = pc_ff & PC_ALIGN;
   assign seq_pc   = pc_ff + (c1[15] ? 32'd4 : 32'd2);
   assign imm16_sx = {{16{c2[15]}}, c2};
   assign imm8_sx  = {{24{c1[7]}}, c1[7:0]};
   assign br16_off = {{14{c2[15]}}, c2, 2'b00};
   assign br8_off  = {{22{c1[7]}}, c1[7:0], 2'b00};
   assign prod     = s1_a_ff * s1_b_ff;

   // Execute one instruction
   always_comb begin
      ex_status = ST_DONE;
      ex_next   = seq_pc;
      ex_wr     = 1'b0;
      ex_widx   = c1[11:8];
      ex_wval   = '0;
      ex_carry  = carry_ff;
      known     = 1'b1;
      if (halted_ff) begin
         ex_status = ST_HALTED;
         ex_next   = pc_ff;
      end else if (seq_pc >= MEM_LIMIT) begin
         ex_status = ST_PC_RANGE;
      end else begin
         unique case (c1 & MASK_MAJOR)
            OPC_ADD: begin ex_wr = 1'b1; ex_wval = s1_a_ff + s1_b_ff; end
            OPC_ADD3: begin ex_wr = 1'b1; ex_wval = s1_b_ff + imm16_sx; end
            OPC_AND: begin ex_wr = 1'b1; ex_wval = s1_a_ff & s1_b_ff; end
            OPC_BEQ: begin
               if (s1_a_ff == s1_b_ff) ex_next = base_pc + br16_off;
            end
            OPC_CMP: ex_carry = $signed(s1_a_ff) < $signed(s1_b_ff);
            OPC_MUL: begin ex_wr = 1'b1; ex_wval = prod; end
            OPC_MV: begin ex_wr = 1'b1; ex_wval = s1_b_ff; end
            OPC_NEG: begin ex_wr = 1'b1; ex_wval = 32'd0 - s1_b_ff; end
            OPC_NOT: begin ex_wr = 1'b1; ex_wval = ~s1_b_ff; end
            OPC_OR: begin ex_wr = 1'b1; ex_wval = s1_a_ff | s1_b_ff; end
            OPC_OR3: begin ex_wr = 1'b1; ex_wval = s1_b_ff | {16'd0, c2}; end
            OPC_SLL: begin ex_wr = 1'b1; ex_wval = s1_a_ff << s1_b_ff[4:0]; end
            OPC_SLLI_A, OPC_SLLI_B: begin
               ex_wr = 1'b1; ex_wval = s1_a_ff << c1[4:0];
            end
            OPC_SRL: begin ex_wr = 1'b1; ex_wval = s1_a_ff >> s1_b_ff[4:0]; end
            OPC_SRLI_A, OPC_SRLI_B: begin
               ex_wr = 1'b1; ex_wval = s1_a_ff >> c1[4:0];
            end
            OPC_SUB: begin ex_wr = 1'b1; ex_wval = s1_a_ff - s1_b_ff; end
            OPC_XOR: begin ex_wr = 1'b1; ex_wval = s1_a_ff ^ s1_b_ff; end
            default: begin
               priority if ((c1 & MASK_HIGH) == OPC_BC) begin
                  if (carry_ff) ex_next = base_pc + br8_off;
               end else if ((c1 & MASK_HIGH) == OPC_BRA) begin
                  ex_next = base_pc + br8_off;
               end else if ((c1 & MASK_RS) == OPC_CMPI) begin
                  ex_carry = $signed(s1_b_ff) < $signed(imm16_sx);
               end else if ((c1 & MASK_RS) == OPC_JL) begin
                  // target from Rs as read, before the link write
                  ex_next = s1_b_ff & PC_ALIGN;
                  ex_wr   = 1'b1;
                  ex_widx = LINK_REG;
                  ex_wval = base_pc + 32'd4;
               end else if ((c1 & MASK_RS) == OPC_JMP) begin
                  ex_next = s1_b_ff & PC_ALIGN;
               end else if ((c1 & MASK_RS) == OPC_TRAP) begin
                  if (c1[3:0] == 4'd0) ex_status = ST_TRAP_STOP;
               end else if ((c1 & MASK_TOP) == OPC_ADDI) begin
                  ex_wr = 1'b1; ex_wval = s1_a_ff + imm8_sx;
               end else if ((c1 & MASK_RD) == OPC_LDI) begin
                  ex_wr = 1'b1; ex_wval = imm16_sx;
               end else if (c1 == OPC_NOP) begin
                  ex_wr = 1'b0;
               end else if ((c1 & MASK_RD) == OPC_SETH) begin
                  ex_wr = 1'b1; ex_wval = {c2, 16'd0};
               end else begin
                  known = 1'b0;
               end
            end
         endcase
         if (!known) ex_status = ST_DECODE_ERR;
      end
      // stop, decode error and range error freeze the PC and halt
      ex_stop = (ex_status == ST_TRAP_STOP) || (ex_status == ST_DECODE_ERR)
                || (ex_status == ST_PC_RANGE);
      if (ex_stop) begin
         ex_next = pc_ff;
         ex_wr   = 1'b0;
      end
      if (!ex_wr) begin
         ex_widx = '0;
         ex_wval = '0;
      end
   end

   // Next state and result word
   assign rf_we     = s1_move && ex_wr;
   assign pc_in     = s1_move ? ex_next : pc_ff;
   assign carry_in  = s1_move ? ex_carry : carry_ff;
   assign halted_in = halted_ff || (s1_move && ex_stop);
   assign rd_addr   = req_data.first_half[11:8];
   assign rs_addr   = req_data.first_half[3:0];

   always_comb begin
      rsp_word_in.status       = ex_status;
      rsp_word_in.exec_pc      = pc_ff;
      rsp_word_in.following_pc = ex_next;
      rsp_word_in.cond_flag    = ex_carry;
      rsp_word_in.reg_written  = ex_wr;
      rsp_word_in.reg_index    = ex_widx;
      rsp_word_in.reg_value    = $signed(ex_wval);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         carry_ff     <= 1'b0;
         halted_ff    <= 1'b0;
         rf_valid_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff     <= pc_in;
         carry_ff  <= carry_in;
         halted_ff <= halted_in;
         if (rf_we) rf_valid_ff[ex_widx] <= 1'b1;
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Register file write
   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[ex_widx] <= ex_wval;
   end

   // Register file read with bypass, input word register
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_word_ff <= req_data;
         if (rf_we && ex_widx == rd_addr) begin
            s1_a_ff <= ex_wval;
         end else begin
            s1_a_ff <= rf_valid_ff[rd_addr] ? rf_mem[rd_addr] : '0;
         end
         if (rf_we && ex_widx == rs_addr) begin
            s1_b_ff <= ex_wval;
         end else begin
            s1_b_ff <= rf_valid_ff[rs_addr] ? rf_mem[rs_addr] : '0;
         end
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (s1_move) rsp_word_ff <= rsp_word_in;
   end

   // Once halted, every instruction leaving execute reports halted
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      s1_move && halted_ff |=> rsp_word_ff.status == ST_HALTED)
      else $error("instruction executed after halt");

   // Anything but a completed instruction leaves the PC and registers alone
   a_stop_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_word_ff.status != ST_DONE |->
         !rsp_word_ff.reg_written
         && rsp_word_ff.following_pc == rsp_word_ff.exec_pc)
      else $error("stopped instruction had an effect");

   // Results chain: each instruction starts where the last one left off
   a_pc_chain: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> pc_ff == rsp_word_ff.following_pc)
      else $error("PC does not follow result");

   // Request is only held off when the execute stage is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked result");

endmodule
